FILE: rtl/cacd_pkg.sv
// Shared types, constants and calendar functions for the alarm countdown core.
package cacd_pkg;

  localparam int unsigned InWidth  = 40;
  localparam int unsigned OutWidth = 24;

  typedef enum logic [2:0] {
    REG_MONTH_DAY = 3'd0,
    REG_WEEK_DAY  = 3'd1,
    REG_HOUR      = 3'd2,
    REG_MINUTE    = 3'd3,
    REG_SECOND    = 3'd4
  } cfg_reg_e;

  localparam logic [6:0] MOD_MIN   = 7'd60;
  localparam logic [6:0] MOD_HOUR  = 7'd24;
  localparam logic [5:0] FILL_MIN  = 6'd59;
  localparam logic [5:0] FILL_HOUR = 6'd23;
  localparam logic [5:0] MOD_WEEK  = 6'd7;

  localparam logic [3:0] MON_JAN = 4'd0;
  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_MAR = 4'd2;
  localparam logic [3:0] MON_MAY = 4'd4;
  localparam logic [3:0] MON_JUL = 4'd6;
  localparam logic [3:0] MON_AUG = 4'd7;
  localparam logic [3:0] MON_OCT = 4'd9;
  localparam logic [3:0] MON_DEC = 4'd11;

  localparam logic [4:0] LEN_28 = 5'd28;
  localparam logic [4:0] LEN_29 = 5'd29;
  localparam logic [4:0] LEN_30 = 5'd30;
  localparam logic [4:0] LEN_31 = 5'd31;

  // years 1900 and 2100 are not leap years, 2000 is
  localparam logic [7:0] YEAR_1900 = 8'd0;
  localparam logic [7:0] YEAR_2100 = 8'd200;

  typedef struct packed {
    logic unused;
    logic follow;
    logic borrow;
    logic inc;
    logic is_hour;
  } field_ctl_t;

  function automatic logic is_leap(input logic [7:0] year);
    return (year[1:0] == 2'b00) && (year != YEAR_1900) && (year != YEAR_2100);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon) inside
      MON_FEB: len = leap ? LEN_29 : LEN_28;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = LEN_31;
      default: len = LEN_30;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/cacd_field_step.sv
// One time field of the countdown: target selection, difference and wrap with borrow.
module cacd_field_step (
  input  cacd_pkg::field_ctl_t ctl_i,
  input  logic signed [6:0]    alarm_i,
  input  logic [5:0]           now_i,
  output logic [5:0]           wait_o,
  output logic                 borrow_o
);
  import cacd_pkg::*;

  logic [6:0]        modulus;
  logic [5:0]        fill;
  logic signed [8:0] target;
  logic signed [8:0] diff;
  logic [9:0]        acc;

  always_comb begin
    modulus = ctl_i.is_hour ? MOD_HOUR : MOD_MIN;
    fill    = ctl_i.is_hour ? FILL_HOUR : FILL_MIN;
    if (ctl_i.unused) begin
      if (ctl_i.follow) begin
        target = 9'(now_i) + 9'(ctl_i.inc);
      end else begin
        target = ctl_i.borrow ? 9'(fill) : '0;
      end
    end else begin
      target = 9'(alarm_i) - 9'(ctl_i.borrow);
    end
    diff     = target - 9'(now_i);
    borrow_o = diff[8];
    // lift by eight moduli, then strip binary multiples
    acc = 10'(diff) + {modulus, 3'b000};
    for (int k = 3; k >= 0; k--) begin
      if (acc >= (10'(modulus) << k)) begin
        acc = acc - (10'(modulus) << k);
      end
    end
    wait_o = acc[5:0];
  end

endmodule

FILE: rtl/calendar_alarm_countdown_core.sv
// Top level of the calendar alarm countdown: five-stage pipeline with config registers.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  current broken-down time
//  m_axis    out  m_axis_tvalid/m_axis_tready  days, hours, minutes, seconds to go
//  cfg       in   cfg_we_i                     alarm field registers
//
//  Stages follow the borrow chain: seconds, minutes, hours, day setup, day count.
//  One word enters per cycle unless the pipeline is full and the output stalls.
//  Reset clears the valid bits and loads all alarm fields as unused.
//  Each stage holds only while it is full and the stage after it stalls,
//  so empty stages keep taking words while the output waits.
module calendar_alarm_countdown_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sec[5:0] min[11:6] hour[16:12] mday[21:17] mon[25:22] year[33:26] wday[36:34]
  input  logic [cacd_pkg::InWidth-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // days[5:0] hours[10:6] minutes[16:11] seconds[22:17]
  output logic [cacd_pkg::OutWidth-1:0]    m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_addr_i,
  input  logic [6:0]                       cfg_wdata_i
);
  import cacd_pkg::*;

  typedef enum logic [1:0] {
    DAY_NONE,
    DAY_MDAY,
    DAY_WDAY
  } day_mode_e;

  logic signed [5:0] a_md_q;
  logic signed [3:0] a_wd_q;
  logic signed [5:0] a_hr_q;
  logic signed [6:0] a_mi_q;
  logic signed [6:0] a_se_q;

  logic [4:0] vld_q;
  logic [4:0] en;

  logic [5:0] in_sec, in_min;
  logic [4:0] in_hour, in_mday;
  logic [3:0] in_mon;
  logic [7:0] in_year;
  logic [2:0] in_wday;

  logic       no_day;
  field_ctl_t ctl_sec, ctl_min, ctl_hour;

  // stage 1
  logic [5:0] s1_sec_d, s1_sec_q, s1_min_q;
  logic       s1_b_d, s1_b_q;
  logic [4:0] s1_hour_q, s1_mday_q;
  logic [3:0] s1_mon_q;
  logic [7:0] s1_year_q;
  logic [2:0] s1_wday_q;

  // stage 2
  logic [5:0] s2_min_d, s2_min_q, s2_sec_q;
  logic       s2_b_d, s2_b_q;
  logic [4:0] s2_hour_q, s2_mday_q;
  logic [2:0] s2_wday_q;
  logic       s1_leap;
  logic [4:0] s2_lcur_d, s2_lcur_q, s2_lnxt_d, s2_lnxt_q;

  // stage 3
  logic [5:0] s3_hour_d, s3_min_q, s3_sec_q;
  logic [4:0] s3_hour_q;
  logic       s3_b_d, s3_b_q;
  logic [4:0] s3_mday_q, s3_lcur_q, s3_lnxt_q;
  logic [2:0] s3_wday_q;

  // stage 4
  logic signed [6:0] want, req, goal0, lcur_s, lnxt_s, mday_s;
  logic              moved;
  logic signed [6:0] s4_goal_d, s4_goal_q, s4_extra_d, s4_extra_q;
  logic [4:0]        s4_from_d, s4_from_q, s4_lenx_d, s4_lenx_q;
  logic signed [4:0] wd_want;
  logic [5:0]        wd_acc;
  logic [2:0]        s4_wd_d, s4_wd_q;
  day_mode_e         s4_mode_d, s4_mode_q;
  logic [4:0]        s4_hour_q;
  logic [5:0]        s4_min_q, s4_sec_q;

  // stage 5
  logic signed [7:0] dd, total;
  logic [5:0]        s5_days_d, s5_days_q, s5_min_q, s5_sec_q;
  logic [4:0]        s5_hour_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_md_q <= '0;
      a_wd_q <= '1;
      a_hr_q <= '1;
      a_mi_q <= '1;
      a_se_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MONTH_DAY: a_md_q <= cfg_wdata_i[5:0];
        REG_WEEK_DAY:  a_wd_q <= cfg_wdata_i[3:0];
        REG_HOUR:      a_hr_q <= cfg_wdata_i[5:0];
        REG_MINUTE:    a_mi_q <= cfg_wdata_i;
        REG_SECOND:    a_se_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stall chain
  always_comb begin
    en[4] = !vld_q[4] || m_axis_tready;
    for (int k = 3; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < 5; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_sec  = s_axis_tdata[5:0];
  assign in_min  = s_axis_tdata[11:6];
  assign in_hour = s_axis_tdata[16:12];
  assign in_mday = s_axis_tdata[21:17];
  assign in_mon  = s_axis_tdata[25:22];
  assign in_year = s_axis_tdata[33:26];
  assign in_wday = s_axis_tdata[36:34];

  assign no_day = (a_wd_q == '1) && (a_md_q == '0);

  always_comb begin
    ctl_sec.unused  = (a_se_q == '1);
    ctl_sec.follow  = (a_mi_q == '1) && (a_hr_q == '1) && no_day;
    ctl_sec.borrow  = 1'b0;
    ctl_sec.inc     = 1'b1;
    ctl_sec.is_hour = 1'b0;

    ctl_min.unused  = (a_mi_q == '1);
    ctl_min.follow  = (a_hr_q == '1) && no_day;
    ctl_min.borrow  = s1_b_q;
    ctl_min.inc     = s1_b_q;
    ctl_min.is_hour = 1'b0;

    ctl_hour.unused  = (a_hr_q == '1);
    ctl_hour.follow  = no_day;
    ctl_hour.borrow  = s2_b_q;
    ctl_hour.inc     = s2_b_q;
    ctl_hour.is_hour = 1'b1;
  end

  cacd_field_step u_sec (
    .ctl_i    (ctl_sec),
    .alarm_i  (a_se_q),
    .now_i    (in_sec),
    .wait_o   (s1_sec_d),
    .borrow_o (s1_b_d)
  );

  cacd_field_step u_min (
    .ctl_i    (ctl_min),
    .alarm_i  (a_mi_q),
    .now_i    (s1_min_q),
    .wait_o   (s2_min_d),
    .borrow_o (s2_b_d)
  );

  cacd_field_step u_hour (
    .ctl_i    (ctl_hour),
    .alarm_i  (7'(a_hr_q)),
    .now_i    (6'(s2_hour_q)),
    .wait_o   (s3_hour_d),
    .borrow_o (s3_b_d)
  );

  // month lengths of this and the next month
  always_comb begin
    s1_leap   = is_leap(s1_year_q);
    s2_lcur_d = month_len(s1_mon_q, s1_leap);
    s2_lnxt_d = (s1_mon_q >= MON_DEC) ? LEN_31 : month_len(s1_mon_q + 4'd1, s1_leap);
  end

  // day setup
  always_comb begin
    lcur_s = $signed({2'b00, s3_lcur_q});
    lnxt_s = $signed({2'b00, s3_lnxt_q});
    mday_s = $signed({2'b00, s3_mday_q});
    want   = 7'(a_md_q) + $signed({6'd0, s3_b_q});
    req    = (want > 7'sd0) ? want : want + 7'sd1;
    goal0  = (req > 7'sd0) ? req : lcur_s + req;
    moved  = (goal0 < 7'sd0) || (goal0 > lcur_s);
    if (moved) begin
      s4_goal_d  = (goal0 < 7'sd0) ? lnxt_s + req : goal0;
      s4_from_d  = 5'd1;
      s4_extra_d = lcur_s - mday_s + 7'sd1;
      s4_lenx_d  = s3_lnxt_q;
    end else begin
      s4_goal_d  = goal0;
      s4_from_d  = s3_mday_q;
      s4_extra_d = '0;
      s4_lenx_d  = s3_lcur_q;
    end

    wd_want = 5'(a_wd_q) + $signed({4'd0, s3_b_q});
    wd_acc  = 6'(wd_want) - {3'b000, s3_wday_q} + (MOD_WEEK << 2);
    for (int k = 2; k >= 0; k--) begin
      if (wd_acc >= (MOD_WEEK << k)) begin
        wd_acc = wd_acc - (MOD_WEEK << k);
      end
    end
    s4_wd_d = wd_acc[2:0];

    if (a_md_q != '0) begin
      s4_mode_d = DAY_MDAY;
    end else if (a_wd_q != '1) begin
      s4_mode_d = DAY_WDAY;
    end else begin
      s4_mode_d = DAY_NONE;
    end
  end

  // day count
  always_comb begin
    dd = 8'(s4_goal_q) - $signed({3'b000, s4_from_q});
    if (dd < 8'sd0) begin
      dd = dd + $signed({3'b000, s4_lenx_q});
    end
    total = dd + 8'(s4_extra_q);
    case (s4_mode_q)
      DAY_MDAY: begin
        if (total < 8'sd0) begin
          s5_days_d = '0;
        end else if (total > 8'sd63) begin
          s5_days_d = '1;
        end else begin
          s5_days_d = total[5:0];
        end
      end
      DAY_WDAY: s5_days_d = {3'b000, s4_wd_q};
      default:  s5_days_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_mode_q <= DAY_NONE;
    end else if (en[3]) begin
      s4_mode_q <= s4_mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_sec_q  <= s1_sec_d;
      s1_b_q    <= s1_b_d;
      s1_min_q  <= in_min;
      s1_hour_q <= in_hour;
      s1_mday_q <= in_mday;
      s1_mon_q  <= in_mon;
      s1_year_q <= in_year;
      s1_wday_q <= in_wday;
    end
    if (en[1]) begin
      s2_min_q  <= s2_min_d;
      s2_b_q    <= s2_b_d;
      s2_sec_q  <= s1_sec_q;
      s2_hour_q <= s1_hour_q;
      s2_mday_q <= s1_mday_q;
      s2_wday_q <= s1_wday_q;
      s2_lcur_q <= s2_lcur_d;
      s2_lnxt_q <= s2_lnxt_d;
    end
    if (en[2]) begin
      s3_hour_q <= s3_hour_d[4:0];
      s3_b_q    <= s3_b_d;
      s3_min_q  <= s2_min_q;
      s3_sec_q  <= s2_sec_q;
      s3_mday_q <= s2_mday_q;
      s3_wday_q <= s2_wday_q;
      s3_lcur_q <= s2_lcur_q;
      s3_lnxt_q <= s2_lnxt_q;
    end
    if (en[3]) begin
      s4_goal_q  <= s4_goal_d;
      s4_from_q  <= s4_from_d;
      s4_extra_q <= s4_extra_d;
      s4_lenx_q  <= s4_lenx_d;
      s4_wd_q    <= s4_wd_d;
      s4_hour_q  <= s3_hour_q;
      s4_min_q   <= s3_min_q;
      s4_sec_q   <= s3_sec_q;
    end
    if (en[4]) begin
      s5_days_q <= s5_days_d;
      s5_hour_q <= s4_hour_q;
      s5_min_q  <= s4_min_q;
      s5_sec_q  <= s4_sec_q;
    end
  end

  assign m_axis_tdata = {1'b0, s5_sec_q, s5_min_q, s5_hour_q, s5_days_q};

`ifndef NO_ASSERTIONS
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (s5_hour_q < 5'd24) && (s5_min_q < 6'd60) && (s5_sec_q < 6'd60))
    else $error("countdown field out of range");

  a_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&vld_q) |-> s_axis_tready)
    else $error("input refused while pipeline has a free stage");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && !m_axis_tready) |=> $stable(vld_q))
    else $error("full pipeline moved during output stall");
`endif

endmodule
